FILE: rtl/cwi_pkg.sv
// ----------------------------------------------------------------------------
// cwi_pkg: shared types and constants of the current window integrator
// Holds the command codes, the front-to-back request record and limits.
// ----------------------------------------------------------------------------
package cwi_pkg;

	localparam int unsigned GapW = 16;
	localparam int unsigned CurW = 22;
	localparam int signed CurLimit = 1500000;
	localparam logic [15:0] GapReset = 16'd100;
	localparam logic [15:0] AgeReset = 16'd200;
	localparam int unsigned InW = 64;
	localparam int unsigned OutW = 360;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_BOUNDARY = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_MAX_GAP = 1'b0,
		REG_MAX_AGE = 1'b1
	} reg_idx_t;

	// request from front to back: one classified event
	typedef struct packed {
		logic boundary;
		logic good;
		logic [31:0] tick;
		logic signed [CurW-1:0] cur;
	} req_t;

	// result record, packed fields from lowest bit up are reversed here
	typedef struct packed {
		logic valid;
		logic signed [21:0] max_ma;
		logic signed [21:0] min_ma;
		logic [20:0] rms_ma;
		logic signed [21:0] average_ma;
		logic [52:0] abs_charge;
		logic signed [53:0] charge;
		logic [31:0] invalid_count;
		logic [31:0] accepted_n;
		logic [31:0] stop_ms;
		logic [31:0] start_ms;
		logic [31:0] seq;
	} res_t;

endpackage

FILE: rtl/cwi_front.sv
// ----------------------------------------------------------------------------
// cwi_front: input stage and request queue
// Classifies each input item and holds it in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module cwi_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [cwi_pkg::InW-1:0] in_data,
	output logic req_valid,
	input  logic req_ready,
	output cwi_pkg::req_t req
);

	cwi_pkg::req_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	cwi_pkg::req_t enq;
	logic signed [23:0] cur24;
	logic push, pop;

	always_comb begin
		cur24 = in_data[56:33];
		enq.boundary = in_data[0];
		enq.tick = in_data[32:1];
		enq.good = in_data[57] && (cur24 <= 24'sd1500000) && (cur24 >= -24'sd1500000);
		enq.cur = cur24[cwi_pkg::CurW-1:0];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign req_valid = (cnt_q != 2'd0);
	assign pop = req_valid && req_ready;
	assign req = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= enq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overfill");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");

endmodule

FILE: rtl/cwi_divsqrt.sv
// ----------------------------------------------------------------------------
// cwi_divsqrt: shared iterative unit
// Restoring divide of a 64-bit magnitude by a 33-bit divisor, one bit a cycle,
// or a 64-bit floor square root, one result bit a cycle.
// ----------------------------------------------------------------------------
module cwi_divsqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic op_sqrt,
	input  logic [63:0] num,
	input  logic [32:0] den,
	output logic done,
	output logic [63:0] quo
);

	logic busy_q, sq_q;
	logic [6:0] cnt_q;
	logic [63:0] n_q, q_q;
	logic [64:0] rem_q;
	logic [32:0] d_q;
	logic [64:0] rem_sh, trial;
	logic [65:0] rs_sh, rs_tr;

	always_comb begin
		rem_sh = {rem_q[63:0], n_q[63]};
		trial = rem_sh - {32'd0, d_q};
		rs_sh = {rem_q[63:0], n_q[63:62]};
		rs_tr = rs_sh - {q_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
			sq_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				sq_q <= op_sqrt;
				cnt_q <= op_sqrt ? 7'd32 : 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			if (sq_q) begin
				n_q <= {n_q[61:0], 2'b00};
				if (!rs_tr[65]) begin
					rem_q <= rs_tr[64:0];
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					rem_q <= rs_sh[64:0];
					q_q <= {q_q[62:0], 1'b0};
				end
			end else begin
				n_q <= {n_q[62:0], 1'b0};
				if (!trial[64]) begin
					rem_q <= trial;
					q_q <= {q_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					q_q <= {q_q[62:0], 1'b0};
				end
			end
		end
	end

	assign quo = q_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy_q)
		else $error("done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy_q)
		else $error("start lost");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 7'd0)
		else $error("count ran out");

endmodule

FILE: rtl/cwi_back.sv
// ----------------------------------------------------------------------------
// cwi_back: window engine
// Integrates samples one request at a time, closes windows on a boundary
// through the shared divide and root unit, and holds the result register.
// ----------------------------------------------------------------------------
module cwi_back (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  cwi_pkg::req_t req,
	input  logic [15:0] max_gap,
	input  logic [15:0] max_age,
	output logic out_valid,
	input  logic out_ready,
	output cwi_pkg::res_t res
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_M1, S_M2, S_ACC, S_BND, S_DIV, S_DIVW, S_DIV2, S_DIV2W,
		S_SQ, S_SQW, S_EMIT
	} st_t;

	localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] ChMax = 64'sd9007199254740991;

	st_t st_q;
	cwi_pkg::req_t r_q;
	logic started_q, last_ok_q, on_bnd_q, do_int_q;
	logic [31:0] win_start_q, win_end_q, integ_q, last_tick_q;
	logic signed [21:0] last_cur_q, latest_q, min_q, max_q, ia_q, ib_q;
	logic [31:0] samples_q, invalid_q, seq_q, age_q;
	logic signed [63:0] charge_q;
	logic [63:0] abs_q, sq_q;
	logic [15:0] dt_q;
	logic [42:0] sqsum_q;
	logic [22:0] absum_q;
	logic signed [22:0] sum_q;
	logic [58:0] sqp_q;
	logic signed [39:0] chp_q;
	logic [38:0] abp_q;
	logic [31:0] dur_q;
	logic avg_neg_q;
	logic signed [22:0] avg_q;
	logic [63:0] sqq_q;

	logic ds_start, ds_sqrt, ds_done;
	logic [63:0] ds_num, ds_quo;
	logic [32:0] ds_den;

	cwi_divsqrt u_ds (
		.clk(clk), .arst_n(arst_n), .start(ds_start), .op_sqrt(ds_sqrt),
		.num(ds_num), .den(ds_den), .done(ds_done), .quo(ds_quo)
	);

	logic [31:0] tnow, d_end, d_integ, d_last, d_start;
	logic [21:0] ma, mb;
	logic signed [64:0] csum;
	logic [64:0] asum, ssum;
	logic [63:0] chmag;

	always_comb begin
		tnow = r_q.tick;
		d_end = tnow - win_end_q;
		d_integ = tnow - integ_q;
		d_last = tnow - last_tick_q;
		d_start = tnow - win_start_q;
		ma = ia_q[21] ? 22'(-ia_q) : ia_q;
		mb = ib_q[21] ? 22'(-ib_q) : ib_q;
		csum = {charge_q[63], charge_q} + 65'(chp_q);
		asum = {1'b0, abs_q} + {26'd0, abp_q};
		ssum = {1'b0, sq_q} + {6'd0, sqp_q};
		chmag = charge_q[63] ? 64'(-charge_q) : charge_q;
		ds_start = 1'b0;
		ds_sqrt = 1'b0;
		ds_num = chmag;
		ds_den = {dur_q, 1'b0};
		if (st_q == S_DIV) ds_start = 1'b1;
		if (st_q == S_DIV2) begin
			ds_start = 1'b1;
			ds_num = sq_q;
		end
		if (st_q == S_SQ) begin
			ds_start = 1'b1;
			ds_sqrt = 1'b1;
			ds_num = sqq_q;
		end
	end

	assign req_ready = (st_q == S_IDLE);

	function automatic cwi_pkg::res_t snap(input logic [31:0] s, input logic signed [21:0] av,
		input logic [20:0] rm, input logic v, input logic [31:0] st, input logic [31:0] en,
		input logic [31:0] ns, input logic [31:0] ni, input logic signed [63:0] ch,
		input logic [63:0] ab, input logic signed [21:0] mn, input logic signed [21:0] mx);
		cwi_pkg::res_t o;
		logic signed [63:0] h;
		logic [63:0] a;
		// halve toward zero
		h = ch >>> 1;
		if (ch[63] && ch[0]) h = h + 64'sd1;
		a = ab >> 1;
		if (h > ChMax) h = ChMax;
		if (h < -ChMax - 64'sd1) h = -ChMax - 64'sd1;
		if (a > 64'(ChMax)) a = 64'(ChMax);
		o.seq = s; o.start_ms = st; o.stop_ms = en; o.accepted_n = ns;
		o.invalid_count = ni; o.charge = h[53:0]; o.abs_charge = a[52:0];
		o.average_ma = av; o.rms_ma = rm; o.min_ma = mn; o.max_ma = mx; o.valid = v;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			started_q <= 1'b0;
			last_ok_q <= 1'b0;
			win_start_q <= '0; win_end_q <= '0; integ_q <= '0; last_tick_q <= '0;
			last_cur_q <= '0; latest_q <= '0; min_q <= '0; max_q <= '0;
			samples_q <= '0; invalid_q <= '0; seq_q <= '0;
			charge_q <= '0; abs_q <= '0; sq_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						r_q <= req;
						st_q <= S_CHK;
						if (!started_q) begin
							started_q <= 1'b1;
							win_start_q <= req.tick;
							win_end_q <= req.tick;
						end
					end
				end
				S_CHK: begin
					do_int_q <= 1'b0;
					on_bnd_q <= r_q.boundary;
					age_q <= '1;
					st_q <= S_IDLE;
					if (d_end[31]) begin
						if (invalid_q != '1) invalid_q <= invalid_q + 32'd1;
						if (r_q.boundary) begin
							if (!out_valid || out_ready) begin
								res <= snap('0, '0, '0, 1'b0, win_start_q, win_end_q, samples_q,
									(invalid_q != '1) ? invalid_q + 32'd1 : invalid_q,
									charge_q, abs_q, min_q, max_q);
								out_valid <= 1'b1;
							end else begin
								st_q <= S_CHK;
								invalid_q <= invalid_q;
							end
						end
					end else if (!r_q.boundary) begin
						if (!r_q.good) begin
							if (invalid_q != '1) invalid_q <= invalid_q + 32'd1;
							win_end_q <= tnow;
							last_ok_q <= 1'b0;
						end else begin
							st_q <= S_M1;
							ia_q <= r_q.cur; ib_q <= r_q.cur;
							if (last_ok_q) begin
								ia_q <= last_cur_q;
								dt_q <= d_integ[15:0];
								if (d_integ <= {16'd0, max_gap} && d_last <= {16'd0, max_gap})
									do_int_q <= 1'b1;
								else if (invalid_q != '1) invalid_q <= invalid_q + 32'd1;
							end else if (samples_q == '0) begin
								dt_q <= d_start[15:0];
								if (d_start <= {16'd0, max_gap}) do_int_q <= 1'b1;
								else if (invalid_q != '1) invalid_q <= invalid_q + 32'd1;
							end
							if (samples_q == '0 && !last_ok_q) begin
								min_q <= r_q.cur; max_q <= r_q.cur;
							end else begin
								if (r_q.cur < min_q) min_q <= r_q.cur;
								if (r_q.cur > max_q) max_q <= r_q.cur;
							end
							if (samples_q != '1) samples_q <= samples_q + 32'd1;
							win_end_q <= tnow; latest_q <= r_q.cur;
							last_tick_q <= tnow; integ_q <= tnow;
							last_cur_q <= r_q.cur; last_ok_q <= 1'b1;
						end
					end else begin
						st_q <= S_M1;
						ia_q <= last_cur_q; ib_q <= last_cur_q;
						dt_q <= d_integ[15:0];
						if (last_ok_q) begin
							age_q <= d_last;
							if (d_last <= {16'd0, max_age} && d_integ <= {16'd0, max_gap}) begin
								do_int_q <= 1'b1;
								integ_q <= tnow;
							end else begin
								if (invalid_q != '1) invalid_q <= invalid_q + 32'd1;
								last_ok_q <= 1'b0;
							end
						end
					end
				end
				S_M1: begin
					sum_q <= 23'(ia_q) + 23'(ib_q);
					absum_q <= 23'(ma) + 23'(mb);
					sqsum_q <= 43'(ma * ma) + 43'(mb * mb);
					st_q <= S_M2;
				end
				S_M2: begin
					chp_q <= sum_q * $signed({1'b0, dt_q});
					abp_q <= absum_q * dt_q;
					sqp_q <= sqsum_q * dt_q;
					st_q <= S_ACC;
				end
				S_ACC: begin
					if (do_int_q) begin
						if (csum > 65'(SMax)) charge_q <= SMax;
						else if (csum < 65'(SMin)) charge_q <= SMin;
						else charge_q <= csum[63:0];
						abs_q <= asum[64] ? '1 : asum[63:0];
						sq_q <= ssum[64] ? '1 : ssum[63:0];
					end
					st_q <= on_bnd_q ? S_BND : S_IDLE;
				end
				S_BND: begin
					win_end_q <= tnow;
					seq_q <= (seq_q == '1) ? 32'd1 : seq_q + 32'd1;
					dur_q <= d_start;
					avg_neg_q <= charge_q[63];
					st_q <= (d_start != '0) ? S_DIV : S_EMIT;
					avg_q <= (samples_q != '0) ? 23'(latest_q) : '0;
					sqq_q <= (samples_q != '0) ? 64'(latest_q[21] ? 22'(-latest_q) : latest_q) : '0;
				end
				S_DIV: st_q <= S_DIVW;
				S_DIVW: begin
					if (ds_done) begin
						if (ds_quo > 64'd1500000) avg_q <= avg_neg_q ? -23'sd1500000 : 23'sd1500000;
						else avg_q <= avg_neg_q ? -23'(ds_quo) : 23'(ds_quo);
						st_q <= S_DIV2;
					end
				end
				S_DIV2: st_q <= S_DIV2W;
				S_DIV2W: begin
					if (ds_done) begin
						sqq_q <= ds_quo;
						st_q <= S_SQ;
					end
				end
				S_SQ: st_q <= S_SQW;
				S_SQW: begin
					if (ds_done) begin
						sqq_q <= ds_quo;
						st_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid || out_ready) begin
						res <= snap(seq_q, avg_q[21:0],
							(sqq_q > 64'd1500000) ? 21'd1500000 : sqq_q[20:0],
							(samples_q != '0) && (invalid_q == '0) && last_ok_q
								&& (age_q <= {16'd0, max_age}),
							win_start_q, win_end_q, samples_q, invalid_q,
							charge_q, abs_q, min_q, max_q);
						out_valid <= 1'b1;
						st_q <= S_IDLE;
						win_start_q <= win_end_q;
						samples_q <= '0; invalid_q <= '0;
						charge_q <= '0; abs_q <= '0; sq_q <= '0;
						latest_q <= last_ok_q ? last_cur_q : '0;
						min_q <= last_ok_q ? last_cur_q : '0;
						max_q <= last_ok_q ? last_cur_q : '0;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_EMIT && out_valid && !out_ready) |=> st_q == S_EMIT)
		else $error("emit over pending result");
	assert property (@(posedge clk) disable iff (!arst_n) ds_start |-> st_q != S_IDLE)
		else $error("unit started idle");

endmodule

FILE: rtl/current_window_integrator_core.sv
// ----------------------------------------------------------------------------
// current_window_integrator_core: trapezoidal charge integrator over windows
// Use: stream timestamped current samples and window boundaries in on the
// s_axis channel; each boundary returns one window summary on m_axis.
// Samples produce no output. Configuration (max gap, max age) is to be written
// through cfg_we/cfg_idx/cfg_wdata while the block is idle; the block itself
// does not enforce this. A two-entry request queue decouples the input from
// the window engine. A good sample passes through the engine's take, check,
// two multiply stages and accumulate steps; a bad or late sample takes only
// the take and check steps. A boundary adds the close step, two divides
// (charge, square sum) and a square root in the shared iterative unit before
// the summary is emitted. A zero-length window skips the divides and the root;
// a late boundary returns its snapshot from the check step. The engine takes
// one request at a time and accepts the next only when it is back in idle.
// Reset clears all window state and the queue; the first event after
// reset opens the first window at its own timestamp.
// When the receiver stalls, the finished result holds in the output
// register; the engine holds at its next summary, the queue fills, and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module current_window_integrator_core #(
	parameter logic [15:0] GAP_RESET = cwi_pkg::GapReset,
	parameter logic [15:0] AGE_RESET = cwi_pkg::AgeReset
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: cmd[0], tick_ms[32:1], current_ma[56:33], sample_valid[57], zero pad
	input  logic [63:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata: window_seq, window start, window end, good sample total,
	// invalid_count, charge_mams, abs_charge_mams, average_ma, rms_ma, min_ma,
	// max_ma, window_valid, from bit 0 up, zero pad
	output logic [cwi_pkg::OutW-1:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic cfg_idx,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] gap_q, age_q;
	logic req_valid, req_ready;
	cwi_pkg::req_t req;
	cwi_pkg::res_t res;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
			age_q <= AGE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				cwi_pkg::REG_MAX_GAP: gap_q <= cfg_wdata;
				cwi_pkg::REG_MAX_AGE: age_q <= cfg_wdata;
				default: gap_q <= gap_q;
			endcase
		end
	end

	cwi_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.req_valid(req_valid), .req_ready(req_ready), .req(req)
	);

	cwi_back u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.max_gap(gap_q), .max_age(age_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res(res)
	);

	// pack the result record from bit 0 up
	assign m_axis_tdata = {5'd0, res};

endmodule

FILE: dv/tb_current_window_integrator_core.sv
// ----------------------------------------------------------------------------
// tb_current_window_integrator_core: self-checking bench for the window core
// Drives directed and random sample and boundary requests, with random idling
// on both stream sides. An in-bench window model predicts each summary, and
// every returned summary is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_current_window_integrator_core;

	localparam int unsigned ResBits = 355;
	localparam longint ChMax = (longint'(1) << 53) - 1;
	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned Drain = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [cwi_pkg::OutW-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic cfg_idx = cwi_pkg::REG_MAX_GAP;
	logic [15:0] cfg_wdata = '0;

	current_window_integrator_core dut (.*);

	always #5 clk = ~clk;

	// window model state, mirrors the block
	logic [15:0] gap_lim, age_lim;
	bit started;
	logic [31:0] w_start, w_end, integ_tick, last_tick, w_samples, w_invalid, seq_cnt;
	int last_cur, w_latest, w_min, w_max;
	bit last_ok;
	longint chg2;
	longint unsigned abs2, sq2;

	cwi_pkg::res_t summary_q[$];
	int unsigned fails = 0;
	int unsigned cycles = 0;
	bit quiet = 1'b0;
	logic [31:0] now_tick;

	string fname[12] = '{"window_seq", "win_start", "win_stop", "accepted",
		"invalid_count", "charge_mams", "abs_charge_mams", "average_ma", "rms_ma",
		"min_ma", "max_ma", "window_valid"};
	int flo[12] = '{0, 32, 64, 96, 128, 160, 214, 267, 289, 310, 332, 354};
	int fw[12] = '{32, 32, 32, 32, 32, 54, 53, 22, 21, 22, 22, 1};

	function automatic longint sat_add_s(longint a, longint b);
		if (b > 0 && a > 64'sh7fffffffffffffff - b) return 64'sh7fffffffffffffff;
		if (b < 0 && a < -64'sh7fffffffffffffff - 1 - b) return -64'sh7fffffffffffffff - 1;
		return a + b;
	endfunction

	function automatic longint unsigned sat_add_u(longint unsigned a, longint unsigned b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? 64'hffffffffffffffff : s[63:0];
	endfunction

	function automatic longint unsigned magnitude(int v);
		return (v < 0) ? longint'(-longint'(v)) : longint'(v);
	endfunction

	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000000000000000;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic add_trapezoid(int a, int b, logic [31:0] dt);
		longint unsigned ma, mb;
		ma = magnitude(a);
		mb = magnitude(b);
		chg2 = sat_add_s(chg2, (longint'(a) + longint'(b)) * longint'(dt));
		abs2 = sat_add_u(abs2, (ma + mb) * dt);
		sq2 = sat_add_u(sq2, (ma * ma + mb * mb) * dt);
	endtask

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == 32'hffffffff) ? v : v + 1;
	endfunction

	// build one summary from the current window state and queue it
	task automatic push_summary(logic [31:0] seq, longint avg, longint unsigned rms, bit ok);
		cwi_pkg::res_t e;
		longint ch;
		longint unsigned ab;
		ch = chg2 / 2;
		ab = abs2 >> 1;
		if (ch > ChMax) ch = ChMax;
		if (ch < -ChMax - 1) ch = -ChMax - 1;
		if (ab > ChMax) ab = ChMax;
		e.seq = seq;
		e.start_ms = w_start;
		e.stop_ms = w_end;
		e.accepted_n = w_samples;
		e.invalid_count = w_invalid;
		e.charge = ch[53:0];
		e.abs_charge = ab[52:0];
		e.average_ma = avg[21:0];
		e.rms_ma = rms[20:0];
		e.min_ma = w_min[21:0];
		e.max_ma = w_max[21:0];
		e.valid = ok;
		summary_q.push_back(e);
	endtask

	task automatic window_reset();
		gap_lim = cwi_pkg::GapReset;
		age_lim = cwi_pkg::AgeReset;
		started = 0;
		w_start = 0; w_end = 0; integ_tick = 0; last_tick = 0;
		w_samples = 0; w_invalid = 0; seq_cnt = 0;
		last_cur = 0; w_latest = 0; w_min = 0; w_max = 0;
		last_ok = 0;
		chg2 = 0; abs2 = 0; sq2 = 0;
	endtask

	task automatic window_sample(logic [31:0] t, int cur, bit good);
		logic [31:0] dt;
		if (!good || cur > cwi_pkg::CurLimit || cur < -cwi_pkg::CurLimit) begin
			w_invalid = bump(w_invalid);
			w_end = t;
			last_ok = 0;
			return;
		end
		if (last_ok) begin
			dt = t - integ_tick;
			if (dt <= gap_lim && (t - last_tick) <= gap_lim) add_trapezoid(last_cur, cur, dt);
			else w_invalid = bump(w_invalid);
		end else if (w_samples == 0) begin
			dt = t - w_start;
			if (dt <= gap_lim) add_trapezoid(cur, cur, dt);
			else w_invalid = bump(w_invalid);
		end
		if (w_samples == 0 && !last_ok) begin
			w_min = cur;
			w_max = cur;
		end else begin
			if (cur < w_min) w_min = cur;
			if (cur > w_max) w_max = cur;
		end
		w_samples = bump(w_samples);
		w_end = t;
		w_latest = cur;
		last_tick = t;
		integ_tick = t;
		last_cur = cur;
		last_ok = 1;
	endtask

	task automatic window_close(logic [31:0] t);
		logic [31:0] age, pend, dur, seq;
		longint avg;
		longint unsigned rms;
		bit ok;
		age = 32'hffffffff;
		avg = 0;
		rms = 0;
		if (last_ok) begin
			pend = t - integ_tick;
			age = t - last_tick;
			if (age <= age_lim && pend <= gap_lim) begin
				add_trapezoid(last_cur, last_cur, pend);
				integ_tick = t;
			end else begin
				w_invalid = bump(w_invalid);
				last_ok = 0;
			end
		end
		w_end = t;
		seq = seq_cnt + 1;
		if (seq == 0) seq = 1;
		seq_cnt = seq;
		dur = t - w_start;
		if (dur > 0) begin
			avg = chg2 / (2 * longint'(dur));
			rms = floor_root(sq2 / (2 * longint'(dur)));
		end else if (w_samples > 0) begin
			avg = w_latest;
			rms = magnitude(w_latest);
		end
		if (avg > cwi_pkg::CurLimit) avg = cwi_pkg::CurLimit;
		if (avg < -cwi_pkg::CurLimit) avg = -cwi_pkg::CurLimit;
		if (rms > cwi_pkg::CurLimit) rms = cwi_pkg::CurLimit;
		ok = w_samples > 0 && w_invalid == 0 && last_ok && age <= age_lim;
		push_summary(seq, avg, rms, ok);
		w_start = t;
		w_end = t;
		w_samples = 0;
		w_invalid = 0;
		chg2 = 0; abs2 = 0; sq2 = 0;
		w_latest = last_ok ? last_cur : 0;
		w_min = w_latest;
		w_max = w_latest;
	endtask

	// predict the effect of one accepted request
	task automatic window_event(cwi_pkg::cmd_t c, logic [31:0] t, logic [23:0] raw, bit good);
		int cur;
		cur = int'(signed'(raw));
		if (!started) begin
			started = 1;
			w_start = t;
			w_end = t;
		end
		if ((t - w_end) > 32'h7fffffff) begin
			// late: count it, a late boundary returns a snapshot only
			w_invalid = bump(w_invalid);
			if (c == cwi_pkg::CMD_BOUNDARY) push_summary(0, 0, 0, 0);
		end else if (c == cwi_pkg::CMD_SAMPLE) begin
			window_sample(t, cur, good);
		end else begin
			window_close(t);
		end
	endtask

	// send one request, wait for the handshake, then maybe idle
	task automatic send_req(cwi_pkg::cmd_t c, logic [31:0] t, logic [23:0] cur, bit good);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, good, cur, t, c};
		do @(posedge clk); while (!s_axis_tready);
		window_event(c, t, cur, good);
		now_tick = t;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// hold until every summary is back, then let the engine settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (summary_q.size() != 0) @(posedge clk);
		repeat (Drain) @(posedge clk);
	endtask

	task automatic write_reg(cwi_pkg::reg_idx_t idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == cwi_pkg::REG_MAX_GAP) gap_lim = v;
		else age_lim = v;
	endtask

	// one random request: mostly well-formed streams, some noise
	task automatic random_req();
		int unsigned pick, span;
		logic [31:0] t;
		logic [23:0] cur;
		bit good;
		cwi_pkg::cmd_t c;
		pick = $urandom_range(0, 99);
		span = gap_lim + gap_lim / 8 + 2;
		t = now_tick + $urandom_range(0, span);
		cur = 24'($urandom_range(0, 3000000)) - 24'd1500000;
		good = 1'b1;
		c = ($urandom_range(0, 9) == 0) ? cwi_pkg::CMD_BOUNDARY : cwi_pkg::CMD_SAMPLE;
		if (pick < 4) cur = 24'($urandom);
		else if (pick < 8) good = 1'b0;
		else if (pick < 11) t = w_end + 32'h80000000 + $urandom_range(0, 32'h7ffffff0);
		else if (pick < 13) t = now_tick + $urandom_range(0, 32'h7fffffff);
		else if (pick < 16) t = now_tick + age_lim + $urandom_range(0, 300);
		else if (pick < 18) cur = $urandom_range(0, 1) ? 24'd1500000 : -24'sd1500000;
		send_req(c, t, cur, good);
	endtask

	task automatic random_run(int unsigned n);
		repeat (n) random_req();
	endtask

	// extremes of the fields and each special case after reset
	task automatic test_directed();
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1000, 24'd1500000, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1050, -24'sd1500000, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1060, 24'd1500001, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1070, 24'h7fffff, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1080, 24'h800000, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1090, 24'd5, 0);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1100, 24'd12345, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'd1150, 24'd0, 1);
		// zero-length window with no samples, then with one sample
		send_req(cwi_pkg::CMD_BOUNDARY, 32'd1150, 24'd0, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1150, -24'sd777, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'd1150, 24'd0, 1);
		// clean window held back to its start
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1190, 24'd1000, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1240, 24'd3000, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'd1300, 24'd0, 0);
		// gap too long, then a stale tail
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1500, 24'd10, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1550, 24'd20, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'd1900, 24'd0, 1);
		// late sample and late boundary
		send_req(cwi_pkg::CMD_SAMPLE, 32'h80001000, 24'd1, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'h90000000, 24'd0, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'hffffffff, 24'hffffff, 1);
		send_req(cwi_pkg::CMD_SAMPLE, 32'd1950, 24'd0, 1);
		send_req(cwi_pkg::CMD_BOUNDARY, 32'd2000, 24'd0, 1);
		wait_idle();
	endtask

	task automatic test_tight_limits();
		write_reg(cwi_pkg::REG_MAX_GAP, 16'd0);
		write_reg(cwi_pkg::REG_MAX_AGE, 16'd0);
		random_run(150);
		wait_idle();
	endtask

	task automatic test_wide_limits();
		write_reg(cwi_pkg::REG_MAX_GAP, 16'hffff);
		write_reg(cwi_pkg::REG_MAX_AGE, 16'hffff);
		random_run(200);
		wait_idle();
	endtask

	task automatic test_mixed_limits();
		write_reg(cwi_pkg::REG_MAX_GAP, 16'($urandom_range(1, 2000)));
		write_reg(cwi_pkg::REG_MAX_AGE, 16'($urandom_range(1, 4000)));
		random_run(300);
		wait_idle();
	endtask

	task automatic test_default_limits();
		write_reg(cwi_pkg::REG_MAX_GAP, cwi_pkg::GapReset);
		write_reg(cwi_pkg::REG_MAX_AGE, cwi_pkg::AgeReset);
		random_run(200);
		// last stretch: no idling on either side
		quiet = 1'b1;
		random_run(100);
		wait_idle();
	endtask

	// receiver stall bursts
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 11);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each accepted summary with the oldest prediction
	always @(posedge clk) begin
		logic [ResBits-1:0] got, want;
		logic [63:0] g, w, mask;
		cwi_pkg::res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (summary_q.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected summary %h", m_axis_tdata);
			end else begin
				e = summary_q.pop_front();
				got = m_axis_tdata[ResBits-1:0];
				want = e;
				for (int i = 0; i < 12; i++) begin
					mask = (fw[i] == 64) ? '1 : ((64'd1 << fw[i]) - 1);
					g = 64'(got >> flo[i]) & mask;
					w = 64'(want >> flo[i]) & mask;
					if (g !== w) begin
						fails++;
						if (fails <= 10)
							$display("%s mismatch: expected %h got %h", fname[i], w, g);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		window_reset();
		now_tick = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tight_limits();
		test_wide_limits();
		test_mixed_limits();
		test_default_limits();
		if (summary_q.size() != 0) fails++;
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
